// ----- rtl/core/bpag_pkg.sv -----
`default_nettype none

package bpag_pkg;

  // Default values of the top-level parameters
  localparam int MaxDimsDef    = 4;
  localparam int DimBitsDef    = 16;
  localparam int OffsetBitsDef = 32;

  // Fixed widths of the register file and the element counter
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int RankW    = 3;
  localparam int ShapeW   = 64;
  localparam int CountW   = 32;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANK_A    = 3'd0,
    CFG_RANK_B    = 3'd1,
    CFG_SHAPE_A   = 3'd2,
    CFG_SHAPE_B   = 3'd3,
    CFG_OUT_SHAPE = 3'd4,
    CFG_OUT_COUNT = 3'd5
  } cfg_idx_e;

  // Step command broadcast to every cell of the chain
  typedef struct packed {
    logic start;    // restart at element zero and latch fresh strides
    logic advance;  // step the odometer by one element
  } step_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/broadcast_pair_address_gen_top.sv -----
`default_nettype none

// Broadcast address generator for element-wise binary tensor operations. Each
// request produces one output element: its linear index, the element offsets
// of operand a and operand b under right-aligned broadcasting, and a last flag.
// A request with restart set, the first one after reset, and the one after the
// last element start again at element zero and latch the strides. One request
// is taken every cycle unless stalled; the carry ripples through the chain of
// MAX_DIMS dimension cells within that cycle. The strides come out of a
// pipelined running product, one cell per cycle, so after reset and after
// every configuration write the input stalls while it settles.
module broadcast_pair_address_gen_top
  import bpag_pkg::*;
#(
  parameter int MAX_DIMS    = MaxDimsDef,
  parameter int DIM_BITS    = DimBitsDef,
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [CfgDataW-1:0]    cfg_data_i,
  // step requests
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   restart_i,
  // results
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [CountW-1:0]      out_index_o,
  output logic      [OFFSET_BITS-1:0] offset_a_o,
  output logic      [OFFSET_BITS-1:0] offset_b_o,
  output logic                        last_o
);

  localparam int SettleW = $clog2(MAX_DIMS + 1);
  localparam int RankCW  = RankW + 1;

  logic [RankW-1:0]   rank_a_q, rank_b_q;
  logic [ShapeW-1:0]  shape_a_q, shape_b_q, out_shape_q;
  logic [CountW-1:0]  out_count_q;
  logic [SettleW-1:0] settle_q;
  logic [RankCW-1:0]  ra_c, rb_c, nd;

  logic [CountW-1:0]  cnt_d, cnt_q, last_index;
  logic               last_d, last_q, started_q, out_valid_q;
  logic               in_accept, out_take, begin_zero;
  step_ctrl_t         ctrl;

  logic [MAX_DIMS:0][OFFSET_BITS-1:0]   run_a, run_b, sum_a, sum_b;
  logic [MAX_DIMS:0]                    carry;
  logic [MAX_DIMS-1:0]                  sel;
  logic [MAX_DIMS-1:0][OFFSET_BITS-1:0] cand_a, cand_b;
  logic [OFFSET_BITS-1:0]               delta_a, delta_b;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_a_q    <= RankW'(1);
      rank_b_q    <= RankW'(1);
      shape_a_q   <= ShapeW'(1);
      shape_b_q   <= ShapeW'(1);
      out_shape_q <= ShapeW'(1);
      out_count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANK_A:    rank_a_q    <= cfg_data_i[RankW-1:0];
        CFG_RANK_B:    rank_b_q    <= cfg_data_i[RankW-1:0];
        CFG_SHAPE_A:   shape_a_q   <= cfg_data_i[ShapeW-1:0];
        CFG_SHAPE_B:   shape_b_q   <= cfg_data_i[ShapeW-1:0];
        CFG_OUT_SHAPE: out_shape_q <= cfg_data_i[ShapeW-1:0];
        CFG_OUT_COUNT: out_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Hold off requests until the stride chain has settled on the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleW'(MAX_DIMS);
    end else if (cfg_we_i) begin
      settle_q <= SettleW'(MAX_DIMS);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - SettleW'(1);
    end
  end

  // Clamp the ranks and find the number of active dimensions
  always_comb begin
    ra_c = ({1'b0, rank_a_q} > RankCW'(MAX_DIMS)) ? RankCW'(MAX_DIMS) : {1'b0, rank_a_q};
    rb_c = ({1'b0, rank_b_q} > RankCW'(MAX_DIMS)) ? RankCW'(MAX_DIMS) : {1'b0, rank_b_q};
    nd   = (ra_c > rb_c) ? ra_c : rb_c;
  end

  // Handshake
  assign in_stall_o = (settle_q != '0) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign last_index = out_count_q - CountW'(1);
  assign begin_zero = restart_i || !started_q || (cnt_q == last_index);

  always_comb begin
    ctrl.start   = in_accept && begin_zero;
    ctrl.advance = in_accept && !begin_zero;
  end

  // Element counter and last flag
  assign cnt_d  = begin_zero ? '0 : cnt_q + CountW'(1);
  assign last_d = (cnt_d == last_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_q      <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        cnt_q       <= cnt_d;
        last_q      <= last_d;
        started_q   <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Chain of dimension cells, innermost first
  assign run_a[0] = OFFSET_BITS'(1);
  assign run_b[0] = OFFSET_BITS'(1);
  assign sum_a[0] = '0;
  assign sum_b[0] = '0;
  assign carry[0] = 1'b1;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
    logic [DIM_BITS-1:0] fld_a, fld_b, fld_o, dim_a, dim_b;
    logic                active;

    assign fld_a  = DIM_BITS'(shape_a_q >> (k * DIM_BITS));
    assign fld_b  = DIM_BITS'(shape_b_q >> (k * DIM_BITS));
    assign fld_o  = DIM_BITS'(out_shape_q >> (k * DIM_BITS));
    assign dim_a  = (ra_c > RankCW'(k)) ? fld_a : DIM_BITS'(1);
    assign dim_b  = (rb_c > RankCW'(k)) ? fld_b : DIM_BITS'(1);
    assign active = nd > RankCW'(k);

    bpag_cell #(
      .DIM_BITS    (DIM_BITS),
      .OFFSET_BITS (OFFSET_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (active),
      .dim_a_i      (dim_a),
      .dim_b_i      (dim_b),
      .dim_o_i      (fld_o),
      .run_a_i      (run_a[k]),
      .run_b_i      (run_b[k]),
      .run_a_o      (run_a[k+1]),
      .run_b_o      (run_b[k+1]),
      .carry_i      (carry[k]),
      .carry_o      (carry[k+1]),
      .sel_o        (sel[k]),
      .prev_sum_a_i (sum_a[k]),
      .prev_sum_b_i (sum_b[k]),
      .sum_a_o      (sum_a[k+1]),
      .sum_b_o      (sum_b[k+1]),
      .delta_a_o    (cand_a[k]),
      .delta_b_o    (cand_b[k]),
      .delta_a_i    (delta_a),
      .delta_b_i    (delta_b)
    );
  end

  // Pick the change offered by the cell where the carry stops
  always_comb begin
    delta_a = '0;
    delta_b = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      delta_a = delta_a | (sel[k] ? cand_a[k] : '0);
      delta_b = delta_b | (sel[k] ? cand_b[k] : '0);
    end
  end

  // Results: the outermost prefix is the running offset
  assign out_valid_o = out_valid_q;
  assign out_index_o = cnt_q;
  assign offset_a_o  = sum_a[MAX_DIMS];
  assign offset_b_o  = sum_b[MAX_DIMS];
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/bpag_cell.sv -----
`default_nettype none

// One dimension of the broadcast walk. The cell computes its stride stage from
// the running product handed in by the cell below, holds its digit, and holds
// the inclusive prefix of stride*digit over itself and all inner cells.
module bpag_cell
  import bpag_pkg::*;
#(
  parameter int DIM_BITS    = DimBitsDef,
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire step_ctrl_t             ctrl_i,
  input  wire logic                   active_i,
  input  wire logic [DIM_BITS-1:0]    dim_a_i,
  input  wire logic [DIM_BITS-1:0]    dim_b_i,
  input  wire logic [DIM_BITS-1:0]    dim_o_i,
  input  wire logic [OFFSET_BITS-1:0] run_a_i,
  input  wire logic [OFFSET_BITS-1:0] run_b_i,
  output logic      [OFFSET_BITS-1:0] run_a_o,
  output logic      [OFFSET_BITS-1:0] run_b_o,
  input  wire logic                   carry_i,
  output logic                        carry_o,
  output logic                        sel_o,
  input  wire logic [OFFSET_BITS-1:0] prev_sum_a_i,
  input  wire logic [OFFSET_BITS-1:0] prev_sum_b_i,
  output logic      [OFFSET_BITS-1:0] sum_a_o,
  output logic      [OFFSET_BITS-1:0] sum_b_o,
  output logic      [OFFSET_BITS-1:0] delta_a_o,
  output logic      [OFFSET_BITS-1:0] delta_b_o,
  input  wire logic [OFFSET_BITS-1:0] delta_a_i,
  input  wire logic [OFFSET_BITS-1:0] delta_b_i
);

  logic [OFFSET_BITS-1:0]          prod_a, prod_b;
  logic                            match_a, match_b;
  logic [OFFSET_BITS-1:0]          run_a_d, run_a_q, run_b_d, run_b_q;
  logic [OFFSET_BITS-1:0]          pend_a_d, pend_a_q, pend_b_d, pend_b_q;
  logic [OFFSET_BITS-1:0]          stride_a_q, stride_b_q;
  logic [OFFSET_BITS-1:0]          sum_a_d, sum_a_q, sum_b_d, sum_b_q;
  logic [DIM_BITS-1:0]             digit_d, digit_q;
  logic [DIM_BITS:0]               digit_inc;
  logic                            can_inc, inc, wrap;

  // Stride stage: take the running product from the inner cell and pass it on
  assign match_a = active_i && (dim_a_i == dim_o_i);
  assign match_b = active_i && (dim_b_i == dim_o_i);
  assign prod_a  = run_a_i * OFFSET_BITS'(dim_a_i);
  assign prod_b  = run_b_i * OFFSET_BITS'(dim_b_i);

  always_comb begin
    pend_a_d = match_a ? run_a_i : '0;
    pend_b_d = match_b ? run_b_i : '0;
    run_a_d  = match_a ? prod_a : run_a_i;
    run_b_d  = match_b ? prod_b : run_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_a_q  <= '0;
      run_b_q  <= '0;
      pend_a_q <= '0;
      pend_b_q <= '0;
    end else begin
      run_a_q  <= run_a_d;
      run_b_q  <= run_b_d;
      pend_a_q <= pend_a_d;
      pend_b_q <= pend_b_d;
    end
  end

  assign run_a_o = run_a_q;
  assign run_b_o = run_b_q;

  // Odometer digit: count up below the output size, else wrap and carry out
  assign digit_inc = {1'b0, digit_q} + {{DIM_BITS{1'b0}}, 1'b1};
  assign can_inc   = digit_inc < {1'b0, dim_o_i};
  assign inc       = carry_i && active_i && can_inc;
  assign wrap      = active_i && !can_inc;
  assign carry_o   = carry_i && wrap;
  assign sel_o     = carry_i && !wrap;

  // Offer this cell's offset change in case the carry stops here
  assign delta_a_o = (inc ? stride_a_q : '0) - prev_sum_a_i;
  assign delta_b_o = (inc ? stride_b_q : '0) - prev_sum_b_i;

  // Clear on start or when the carry passes through, else apply the chosen change
  always_comb begin
    digit_d = digit_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (ctrl_i.start) begin
      digit_d = '0;
      sum_a_d = '0;
      sum_b_d = '0;
    end else if (ctrl_i.advance) begin
      if (carry_o) begin
        digit_d = '0;
        sum_a_d = '0;
        sum_b_d = '0;
      end else begin
        sum_a_d = sum_a_q + delta_a_i;
        sum_b_d = sum_b_q + delta_b_i;
        if (inc) begin
          digit_d = digit_inc[DIM_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q    <= '0;
      sum_a_q    <= '0;
      sum_b_q    <= '0;
      stride_a_q <= '0;
      stride_b_q <= '0;
    end else begin
      digit_q <= digit_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      if (ctrl_i.start) begin
        stride_a_q <= pend_a_q;
        stride_b_q <= pend_b_q;
      end
    end
  end

  assign sum_a_o = sum_a_q;
  assign sum_b_o = sum_b_q;

endmodule

`default_nettype wire

// ----- tb/broadcast_pair_address_gen_top_test.sv -----
module broadcast_pair_address_gen_top_test
  import bpag_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LongHold = 300;

  // Tracks the odometer of the generator and the element each request must yield
  class pair_offset_scoreboard;
    typedef struct packed {
      logic [CountW-1:0] index;
      logic [31:0]       off_a;
      logic [31:0]       off_b;
      logic              last;
    } elem_rec_t;

    logic [RankW-1:0]  rank_a, rank_b;
    logic [ShapeW-1:0] shape_a, shape_b, out_shape;
    logic [CountW-1:0] out_count;

    logic [15:0]       digit [4];
    logic [31:0]       stride_a [4];
    logic [31:0]       stride_b [4];
    logic [31:0]       off_a, off_b;
    logic [CountW-1:0] elem_idx;
    bit                started;

    elem_rec_t         expected_elems [$];
    int unsigned       errors;

    function new();
      rank_a    = 3'd1;
      rank_b    = 3'd1;
      shape_a   = 64'd1;
      shape_b   = 64'd1;
      out_shape = 64'd1;
      out_count = 32'd1;
      for (int k = 0; k < 4; k++) begin
        digit[k]    = '0;
        stride_a[k] = '0;
        stride_b[k] = '0;
      end
      off_a    = '0;
      off_b    = '0;
      elem_idx = '0;
      started  = 1'b0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_RANK_A:    rank_a = data[RankW-1:0];
        CFG_RANK_B:    rank_b = data[RankW-1:0];
        CFG_SHAPE_A:   shape_a = data;
        CFG_SHAPE_B:   shape_b = data;
        CFG_OUT_SHAPE: out_shape = data;
        CFG_OUT_COUNT: out_count = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned dims_of(logic [RankW-1:0] r);
      return (r > 3'd4) ? 4 : int'(r);
    endfunction

    function logic [15:0] field_of(logic [63:0] word, int k);
      return word[16*k +: 16];
    endfunction

    // Go back to element zero and latch strides from the live registers
    function void restart_odometer();
      int unsigned ra, rb, nd;
      logic [31:0] run_a, run_b;
      logic [15:0] o, da, db;
      ra = dims_of(rank_a);
      rb = dims_of(rank_b);
      nd = (ra > rb) ? ra : rb;
      run_a = 32'd1;
      run_b = 32'd1;
      for (int k = 0; k < 4; k++) begin
        stride_a[k] = '0;
        stride_b[k] = '0;
        digit[k]    = '0;
      end
      for (int k = 0; k < nd; k++) begin
        o  = field_of(out_shape, k);
        da = (k < ra) ? field_of(shape_a, k) : 16'd1;
        db = (k < rb) ? field_of(shape_b, k) : 16'd1;
        if (da == o) begin
          stride_a[k] = run_a;
          run_a       = run_a * 32'(da);
        end
        if (db == o) begin
          stride_b[k] = run_b;
          run_b       = run_b * 32'(db);
        end
      end
      off_a    = '0;
      off_b    = '0;
      elem_idx = '0;
      started  = 1'b1;
    endfunction

    // Advance one element; digits compare against the live output shape
    function void step_odometer();
      int unsigned nd;
      logic [15:0] o;
      nd = (dims_of(rank_a) > dims_of(rank_b)) ? dims_of(rank_a) : dims_of(rank_b);
      elem_idx = elem_idx + 32'd1;
      for (int k = 0; k < nd; k++) begin
        o = field_of(out_shape, k);
        if ({1'b0, digit[k]} + 17'd1 < {1'b0, o}) begin
          digit[k] = digit[k] + 16'd1;
          off_a    = off_a + stride_a[k];
          off_b    = off_b + stride_b[k];
          return;
        end
        off_a    = off_a - stride_a[k] * 32'(digit[k]);
        off_b    = off_b - stride_b[k] * 32'(digit[k]);
        digit[k] = '0;
      end
    endfunction

    function void note_request(logic restart);
      elem_rec_t e;
      if (restart || !started || elem_idx == out_count - 32'd1) restart_odometer();
      else step_odometer();
      e.index = elem_idx;
      e.off_a = off_a;
      e.off_b = off_b;
      e.last  = (elem_idx == out_count - 32'd1);
      expected_elems.push_back(e);
    endfunction

    function void check_result(logic [CountW-1:0] index, logic [31:0] oa, logic [31:0] ob,
                               logic last);
      elem_rec_t e;
      if (expected_elems.size() == 0) begin
        $error("unexpected result: out_index %0d with no request pending", index);
        errors++;
        return;
      end
      e = expected_elems.pop_front();
      if (index !== e.index) begin
        $error("out_index: expected %0d, actual %0d", e.index, index);
        errors++;
      end
      if (oa !== e.off_a) begin
        $error("offset_a: expected 0x%08h, actual 0x%08h", e.off_a, oa);
        errors++;
      end
      if (ob !== e.off_b) begin
        $error("offset_b: expected 0x%08h, actual 0x%08h", e.off_b, ob);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_elems.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  restart_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CountW-1:0]     out_index_o;
  logic [OffsetBitsDef-1:0] offset_a_o;
  logic [OffsetBitsDef-1:0] offset_b_o;
  logic                  last_o;

  pair_offset_scoreboard offset_sb;
  bit                    hold_long;
  bit                    calm;

  broadcast_pair_address_gen_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_index_o(out_index_o),
    .offset_a_o (offset_a_o),
    .offset_b_o (offset_b_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("broadcast_pair_address_gen_top_test: FAIL");
    $finish;
  end

  // Track accepted requests and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) offset_sb.note_request(restart_i);
      if (out_valid_o && !out_stall_i) begin
        offset_sb.check_result(out_index_o, offset_a_o, offset_b_o, last_o);
      end
    end
  end

  // Stall the result side in random bursts, or for one long hold on request
  initial begin
    int unsigned stall_len, run_len;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        stall_len = LongHold;
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) stall_len = $urandom_range(1, 17);
      else stall_len = 0;
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      run_len = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      // Leave the result side open before the next hold
      @(posedge clk_i);
      for (int i = 1; i < run_len && !hold_long; i++) @(posedge clk_i);
    end
  end

  // Offer one request and hold it until taken, then maybe idle a while
  task automatic send_request(input logic restart, input int unsigned gap_odds);
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected element has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (offset_sb.pending() != 0);
  endtask

  task automatic apply_config(input logic [63:0] ra, input logic [63:0] rb,
                              input logic [63:0] sa, input logic [63:0] sbv,
                              input logic [63:0] os, input logic [63:0] cnt);
    cfg_idx_e    reg_order [6];
    logic [63:0] vals [6];
    reg_order = '{CFG_RANK_A, CFG_RANK_B, CFG_SHAPE_A, CFG_SHAPE_B, CFG_OUT_SHAPE,
                  CFG_OUT_COUNT};
    vals = '{ra, rb, sa, sbv, os, cnt};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_order[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      offset_sb.set_reg(reg_order[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Operand size against an output size: mostly matched or broadcast
  function automatic logic [15:0] operand_dim(logic [15:0] o);
    case ($urandom_range(0, 3))
      0, 1:    return o;
      2:       return 16'd1;
      default: return 16'($urandom_range(0, 5));
    endcase
  endfunction

  // Build a random broadcast setup, small enough to wrap often
  task automatic random_config();
    logic [2:0]  ra, rb;
    logic [63:0] sa, sbv, os, junk_a, junk_b, junk_c;
    logic [31:0] cnt, prod;
    logic [15:0] o;
    int unsigned nd, pick;
    nd = $urandom_range(1, 4);
    ra = 3'(nd);
    rb = 3'($urandom_range(1, nd));
    if ($urandom_range(0, 1) == 1) {ra, rb} = {rb, ra};
    pick = $urandom_range(0, 9);
    if (pick == 0) ra = 3'd0;
    else if (pick == 1) rb = 3'($urandom_range(5, 7));
    else if (pick == 2) begin
      ra = 3'd0;
      rb = 3'd0;
    end
    sa   = {$urandom, $urandom};
    sbv  = {$urandom, $urandom};
    os   = {$urandom, $urandom};
    prod = 32'd1;
    for (int k = 0; k < nd; k++) begin
      o = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(1, 4));
      os[16*k +: 16]  = o;
      sa[16*k +: 16]  = operand_dim(o);
      sbv[16*k +: 16] = operand_dim(o);
      prod = prod * 32'(o);
    end
    case ($urandom_range(0, 9))
      7:       cnt = 32'($urandom_range(1, 40));
      8:       cnt = $urandom;
      9:       cnt = ($urandom_range(0, 1) == 1) ? 32'd0 : 32'hFFFF_FFFF;
      default: cnt = (prod == 0) ? 32'($urandom_range(1, 30)) : prod;
    endcase
    // Upper bits beyond a register's width are ignored
    junk_a = '0;
    junk_b = '0;
    junk_c = '0;
    if ($urandom_range(0, 7) == 0) begin
      junk_a = {$urandom, $urandom};
      junk_b = {$urandom, $urandom};
      junk_c = {$urandom, $urandom};
    end
    apply_config({junk_a[63:3], ra}, {junk_b[63:3], rb}, sa, sbv, os, {junk_c[63:32], cnt});
  endtask

  initial begin
    int unsigned sent, phase, phase_items, gap_odds;
    logic        restart;
    offset_sb   = new();
    hold_long   = 1'b0;
    calm        = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    restart_i   <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_RANK_A;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: single element, every step is last
    send_request(1'b0, 0);
    send_request(1'b1, 0);
    send_request(1'b0, 0);
    drain();

    // Full-size shapes latch strides that overflow 32 bits
    apply_config(64'd4, 64'd4, '1, '1, '1, 64'h0000_0000_FFFF_FFFF);
    send_request(1'b1, 0);
    send_request(1'b0, 0);
    drain();

    // Shrink the output shape without a restart; latched strides drive offsets to wrap
    apply_config(64'd4, 64'd4, '1, '1, 64'h0003_0003_0003_0001, 64'h0000_0000_FFFF_FFFF);
    repeat (8) send_request(1'b0, 0);
    drain();

    // Saturated rank against a scalar, sizes 0 and 1, count of zero, outer digit wraps
    apply_config(64'd7, 64'd0, 64'h0001_0000_0002_0003, 64'd0, 64'h0001_0000_0002_0003, 64'd0);
    send_request(1'b1, 0);
    repeat (7) send_request(1'b0, 0);
    drain();

    // Random setups, mostly whole passes over the shape with sparse restarts
    sent  = 0;
    phase = 0;
    while (sent < 800) begin
      random_config();
      phase_items = $urandom_range(8, 48);
      gap_odds    = $urandom_range(0, 4);
      if (phase == 4) begin
        hold_long   = 1'b1;
        gap_odds    = 0;
        phase_items = 40;
      end
      if (sent >= 700) calm = 1'b1;
      for (int i = 0; i < phase_items; i++) begin
        if (i == 0) restart = ($urandom_range(0, 3) != 0);
        else restart = ($urandom_range(0, 19) == 0);
        send_request(restart, gap_odds);
        sent++;
      end
      drain();
      phase++;
    end

    repeat (20) @(posedge clk_i);
    if (offset_sb.errors == 0 && offset_sb.pending() == 0) begin
      $display("broadcast_pair_address_gen_top_test: PASS");
    end else begin
      $display("broadcast_pair_address_gen_top_test: FAIL");
    end
    $finish;
  end

endmodule
